### sv/srle_pkg.sv
// Shared types and constants for the screen run-record pixel decoder.
// Used by the channel interfaces, the decode engine and the top level.
`default_nettype none

package srle_pkg;

  localparam int MAX_WIDTH_DEF    = 4096;
  localparam int ADDRESS_BITS_DEF = 28;

  localparam int FW_W       = 13;
  localparam int FH_W       = 13;
  localparam int PITCH_W    = 16;
  localparam int COLOR_W    = 24;
  localparam int CODE_W     = 8;
  localparam int RUN_W      = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_STEP  = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  localparam logic [CODE_W-1:0] RUN_CODE_LONG = 8'd0;
  localparam logic [CODE_W-1:0] RUN_CODE_COPY = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PREV_LINE_PITCH = 4'd3;

  localparam logic [FW_W-1:0]    FRAME_WIDTH_RST     = 13'd640;
  localparam logic [FH_W-1:0]    FRAME_HEIGHT_RST    = 13'd480;
  localparam logic [PITCH_W-1:0] LINE_PITCH_RST      = 16'd1920;
  localparam logic [PITCH_W-1:0] PREV_LINE_PITCH_RST = 16'd1920;

  typedef struct packed {
    logic [FW_W-1:0]    frame_width;
    logic [FH_W-1:0]    frame_height;
    logic [PITCH_W-1:0] line_pitch;
    logic [PITCH_W-1:0] prev_line_pitch;
  } cfg_t;

  typedef struct packed {
    kind_t               kind;
    logic [COLOR_W-1:0]  fill_color;
    logic [CODE_W-1:0]   run_code;
    logic [RUN_W-1:0]    long_run;
  } item_t;

  typedef struct packed {
    logic has_result;
    logic pixel_valid;
    logic copy_from_prev;
    logic frame_done;
    logic key_frame;
    logic decode_error;
  } res_flags_t;

endpackage

`default_nettype wire

### sv/srle_if.sv
// Valid/ready channel interfaces for the screen run-record pixel decoder.
// Depends on srle_pkg for field widths.
`default_nettype none

interface srle_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [srle_pkg::COLOR_W-1:0] fill_color;
  logic [srle_pkg::CODE_W-1:0]  run_code;
  logic [srle_pkg::RUN_W-1:0]   long_run;

  modport source (output valid, kind, fill_color, run_code, long_run, input ready);
  modport sink (input valid, kind, fill_color, run_code, long_run, output ready);
endinterface

interface srle_out_if #(
  parameter int ADDRESS_BITS = srle_pkg::ADDRESS_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         pixel_valid;
  logic [ADDRESS_BITS-1:0]      write_address;
  logic [srle_pkg::COLOR_W-1:0] pixel_color;
  logic                         copy_from_prev;
  logic [ADDRESS_BITS-1:0]      read_address;
  logic                         frame_done;
  logic                         key_frame;
  logic                         decode_error;

  modport source (output valid, pixel_valid, write_address, pixel_color, copy_from_prev,
                  read_address, frame_done, key_frame, decode_error, input ready);
  modport sink (input valid, pixel_valid, write_address, pixel_color, copy_from_prev,
                read_address, frame_done, key_frame, decode_error, output ready);
endinterface

interface srle_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [srle_pkg::CFG_IDX_W-1:0]  index;
  logic [srle_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/srle_engine.sv
// Decode state and single-pass next-state logic for one input transaction.
// Depends on srle_pkg; instantiated by screen_rle_pixel_decoder_core.
`default_nettype none

module srle_engine #(
  parameter int MAX_WIDTH    = srle_pkg::MAX_WIDTH_DEF,
  parameter int ADDRESS_BITS = srle_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         fire,
  input  wire srle_pkg::item_t              item,
  input  wire srle_pkg::cfg_t               cfg,
  output srle_pkg::res_flags_t              flags,
  output logic [ADDRESS_BITS-1:0]           write_address,
  output logic [srle_pkg::COLOR_W-1:0]      pixel_color,
  output logic [ADDRESS_BITS-1:0]           read_address
);

  localparam int COL_W = $clog2(2 * MAX_WIDTH);
  localparam int CMP_W = (COL_W > srle_pkg::FW_W) ? COL_W : srle_pkg::FW_W;
  localparam logic [COL_W:0] COL_LIMIT = (COL_W + 1)'(2 * MAX_WIDTH);
  localparam int ROOM_W = 34;
  localparam int DIST_W = 18;

  logic [COL_W-1:0]                column_r, column_nxt;
  logic [ADDRESS_BITS-1:0]         wpos_r, wpos_nxt;
  logic [ADDRESS_BITS-1:0]         rpos_r, rpos_nxt;
  logic [srle_pkg::RUN_W-1:0]      remain_r, remain_nxt;
  logic [srle_pkg::COLOR_W-1:0]    color_r, color_nxt;
  logic                            copy_r, copy_nxt;
  logic                            intra_r, intra_nxt;
  logic                            err_r, err_nxt;

  logic signed [13:0]              fh_m1;
  logic signed [30:0]              start_prod;
  logic [31:0]                     start_prod32;
  logic [ADDRESS_BITS-1:0]         start_pos;
  logic [14:0]                     back;
  logic [DIST_W-1:0]               wdist;
  logic [DIST_W-1:0]               rdist;
  logic                            wrap;
  logic [ADDRESS_BITS-1:0]         wpos_adj;
  logic [ADDRESS_BITS-1:0]         rpos_adj;
  logic [COL_W-1:0]                col_base;
  logic [COL_W:0]                  col_inc;
  logic [srle_pkg::RUN_W-1:0]      run_len;
  logic [ROOM_W-1:0]               room_lhs;
  logic [ROOM_W-1:0]               room_rhs;

  assign fh_m1        = $signed({1'b0, cfg.frame_height}) - 14'sd1;
  assign start_prod   = fh_m1 * $signed({1'b0, cfg.line_pitch});
  assign start_prod32 = 32'(start_prod);
  assign start_pos    = start_prod32[ADDRESS_BITS-1:0];

  assign back  = {2'b00, cfg.frame_width} + {1'b0, cfg.frame_width, 1'b0};
  assign wdist = DIST_W'(cfg.line_pitch) + DIST_W'(back);
  assign rdist = DIST_W'(cfg.prev_line_pitch) + DIST_W'(back);
  assign wrap  = (CMP_W'(column_r) == CMP_W'(cfg.frame_width));

  assign wpos_adj = wrap ? (wpos_r - ADDRESS_BITS'(wdist)) : wpos_r;
  assign rpos_adj = (wrap && copy_r) ? (rpos_r - ADDRESS_BITS'(rdist)) : rpos_r;
  assign col_base = wrap ? '0 : column_r;
  assign col_inc  = (COL_W + 1)'(col_base) + (COL_W + 1)'(1);

  always_comb begin
    if (item.run_code == srle_pkg::RUN_CODE_LONG) begin
      run_len = item.long_run;
    end else if (item.run_code == srle_pkg::RUN_CODE_COPY) begin
      run_len = srle_pkg::RUN_W'(item.fill_color);
    end else begin
      run_len = srle_pkg::RUN_W'(item.run_code);
    end
  end

  assign room_lhs = ROOM_W'(wpos_r) + ROOM_W'(cfg.frame_width);
  assign room_rhs = ROOM_W'(run_len) + ROOM_W'(column_r);

  always_comb begin
    column_nxt    = column_r;
    wpos_nxt      = wpos_r;
    rpos_nxt      = rpos_r;
    remain_nxt    = remain_r;
    color_nxt     = color_r;
    copy_nxt      = copy_r;
    intra_nxt     = intra_r;
    err_nxt       = err_r;
    flags         = '0;
    write_address = '0;
    pixel_color   = '0;
    read_address  = '0;
    unique case (item.kind)
      srle_pkg::KIND_START: begin
        column_nxt = '0;
        wpos_nxt   = start_pos;
        rpos_nxt   = '0;
        remain_nxt = '0;
        copy_nxt   = 1'b0;
        intra_nxt  = 1'b1;
        err_nxt    = 1'b0;
      end
      srle_pkg::KIND_RUN: begin
        if (!err_r) begin
          if (room_lhs < room_rhs) begin
            err_nxt    = 1'b1;
            remain_nxt = '0;
          end else begin
            remain_nxt = run_len;
            if (item.run_code == srle_pkg::RUN_CODE_COPY) begin
              copy_nxt  = 1'b1;
              color_nxt = '0;
              rpos_nxt  = wpos_r;
              intra_nxt = 1'b0;
            end else begin
              copy_nxt  = 1'b0;
              color_nxt = item.fill_color;
            end
          end
        end
      end
      srle_pkg::KIND_STEP: begin
        if (remain_r != '0) begin
          flags.has_result     = 1'b1;
          flags.pixel_valid    = 1'b1;
          flags.copy_from_prev = copy_r;
          flags.decode_error   = err_r;
          write_address        = wpos_adj;
          pixel_color          = copy_r ? '0 : color_r;
          read_address         = copy_r ? rpos_adj : '0;
          wpos_nxt             = wpos_adj + ADDRESS_BITS'(3);
          rpos_nxt             = copy_r ? (rpos_adj + ADDRESS_BITS'(3)) : rpos_r;
          column_nxt           = (col_inc >= COL_LIMIT) ? '0 : col_inc[COL_W-1:0];
          remain_nxt           = remain_r - srle_pkg::RUN_W'(1);
        end
      end
      srle_pkg::KIND_END: begin
        remain_nxt         = '0;
        flags.has_result   = 1'b1;
        flags.frame_done   = 1'b1;
        flags.key_frame    = intra_r;
        flags.decode_error = err_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      wpos_r   <= '0;
      rpos_r   <= '0;
      remain_r <= '0;
      color_r  <= '0;
      copy_r   <= 1'b0;
      intra_r  <= 1'b1;
      err_r    <= 1'b0;
    end else if (fire) begin
      column_r <= column_nxt;
      wpos_r   <= wpos_nxt;
      rpos_r   <= rpos_nxt;
      remain_r <= remain_nxt;
      color_r  <= color_nxt;
      copy_r   <= copy_nxt;
      intra_r  <= intra_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/screen_rle_pixel_decoder_core.sv
// Top level of the screen run-record pixel decoder: configuration registers,
// input register, decode engine and result register.
// Depends on srle_pkg, srle_if.sv and srle_engine.
//
// The input channel carries frame starts, run commands, pixel steps and frame
// ends. Each pixel step inside a run yields one pixel write result; each frame
// end yields one frame-done result; other transactions yield no result.
// The configuration channel is always ready and writes one register per
// transaction; the user must use it only while the block is idle, which the
// block itself does not enforce. An accepted transaction is held in the
// input register, decoded in a single pass against the run state, and its
// result is captured in the result register that drives the output channel.
// Unstalled throughput is one transaction per cycle, set by the single decode pass.
// When the receiver stalls, the result register holds and the input register
// fills; input ready drops only when both are occupied.
// Reset restores the register defaults and clears the run state.

`default_nettype none

module screen_rle_pixel_decoder_core #(
  parameter int MAX_WIDTH    = srle_pkg::MAX_WIDTH_DEF,
  parameter int ADDRESS_BITS = srle_pkg::ADDRESS_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  srle_in_if.sink    in_ch,
  srle_out_if.source out_ch,
  srle_cfg_if.sink   cfg_ch
);

  srle_pkg::cfg_t             cfg_r;
  logic                       in_vld_r;
  srle_pkg::item_t            item_r;
  logic                       out_vld_r;
  srle_pkg::res_flags_t       flags_r;
  logic [ADDRESS_BITS-1:0]    waddr_r;
  logic [srle_pkg::COLOR_W-1:0] color_r;
  logic [ADDRESS_BITS-1:0]    raddr_r;

  logic                       fire;
  logic                       in_take;
  srle_pkg::res_flags_t       flags;
  logic [ADDRESS_BITS-1:0]    waddr;
  logic [srle_pkg::COLOR_W-1:0] color;
  logic [ADDRESS_BITS-1:0]    raddr;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width     <= srle_pkg::FRAME_WIDTH_RST;
      cfg_r.frame_height    <= srle_pkg::FRAME_HEIGHT_RST;
      cfg_r.line_pitch      <= srle_pkg::LINE_PITCH_RST;
      cfg_r.prev_line_pitch <= srle_pkg::PREV_LINE_PITCH_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        srle_pkg::REG_FRAME_WIDTH:     cfg_r.frame_width <= cfg_ch.data[srle_pkg::FW_W-1:0];
        srle_pkg::REG_FRAME_HEIGHT:    cfg_r.frame_height <= cfg_ch.data[srle_pkg::FH_W-1:0];
        srle_pkg::REG_LINE_PITCH:      cfg_r.line_pitch <= cfg_ch.data[srle_pkg::PITCH_W-1:0];
        srle_pkg::REG_PREV_LINE_PITCH: begin
          cfg_r.prev_line_pitch <= cfg_ch.data[srle_pkg::PITCH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign fire         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || fire;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.kind       <= srle_pkg::kind_t'(in_ch.kind);
      item_r.fill_color <= in_ch.fill_color;
      item_r.run_code   <= in_ch.run_code;
      item_r.long_run   <= in_ch.long_run;
    end
  end

  srle_engine #(
    .MAX_WIDTH    (MAX_WIDTH),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .item          (item_r),
    .cfg           (cfg_r),
    .flags         (flags),
    .write_address (waddr),
    .pixel_color   (color),
    .read_address  (raddr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= flags.has_result;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && flags.has_result) begin
      flags_r <= flags;
      waddr_r <= waddr;
      color_r <= color;
      raddr_r <= raddr;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.pixel_valid    = flags_r.pixel_valid;
  assign out_ch.write_address  = waddr_r;
  assign out_ch.pixel_color    = color_r;
  assign out_ch.copy_from_prev = flags_r.copy_from_prev;
  assign out_ch.read_address   = raddr_r;
  assign out_ch.frame_done     = flags_r.frame_done;
  assign out_ch.key_frame      = flags_r.key_frame;
  assign out_ch.decode_error   = flags_r.decode_error;

endmodule

`default_nettype wire
